/* rtl/core/blur3_pkg.sv */
package blur3_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_WIDTH_W  = 12;
  localparam int unsigned CFG_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  localparam int unsigned OUT_DEPTH = 8;

  localparam int unsigned VALUE_W = 8;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned ROW_W   = 12;

  typedef struct packed {
    logic               last;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } res_t;

endpackage

/* rtl/core/blur3_ram.sv */
module blur3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/blur3_ofifo.sv */
module blur3_ofifo #(
  parameter int unsigned DEPTH = blur3_pkg::OUT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  blur3_pkg::res_t            push0_i,
  input  blur3_pkg::res_t            push1_i,
  input  logic                       pop_i,
  output blur3_pkg::res_t            head_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] cnt_o
);

  import blur3_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  res_t          mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign wptr_nx = wptr_q + PW'(1);

  always_comb begin
    wptr_d = wptr_q + PW'(push_n_i);
    rptr_d = pop ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wptr_nx] <= push1_i;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign cnt_o   = cnt_q;

endmodule

/* rtl/core/blur_3x3_separable_121.sv */
// Path: a pixel's first result is registered in the s1 stage, then written into
// the output FIFO, from whose head it can transfer.
// Throughput: one pixel per cycle while s_axis_tready is high; a row end stalls
// the input for the edge flush, and on the last row of a plane over one row tall
// two results per column leave the single output port at one per cycle while the sink is ready.
// Reset: position counters and pixel history clear, size returns to 640x480,
// the line stores are not cleared and need no sweep.
module blur_3x3_separable_121 #(
  parameter int unsigned MAX_WIDTH  = blur3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = blur3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [blur3_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [blur3_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,   // value, col, row, pad
  output logic                                m_axis_tlast
);

  import blur3_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WW   = CW + 1;
  localparam int unsigned HW   = RW + 1;
  localparam int unsigned CNTW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned SUMW = CNTW + 2;

  typedef struct packed {
    logic [7:0]    h;
    logic [CW-1:0] x;
    logic [RW-1:0] r;
    logic          ge1;
    logic          ge2;
    logic          rlast;
    logic          lasth;
  } hent_t;

  function automatic int unsigned sat_size(int unsigned v, int unsigned hi);
    int unsigned res;
    res = v;
    if (v == 0) res = 1;
    else if (v > hi) res = hi;
    return res;
  endfunction

  function automatic logic [7:0] tap121(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [9:0] s;
    s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    return s[9:2];
  endfunction

  // size registers, stored saturated
  logic [WW-1:0] w_q;
  logic [HW-1:0] hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= WW'(sat_size(RESET_WIDTH, MAX_WIDTH));
      hh_q <= HW'(sat_size(RESET_HEIGHT, MAX_HEIGHT));
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH: begin
          w_q <= WW'(sat_size(32'(cfg_data_i[CFG_WIDTH_W-1:0]), MAX_WIDTH));
        end
        REG_IMAGE_HEIGHT: begin
          hh_q <= HW'(sat_size(32'(cfg_data_i[CFG_HEIGHT_W-1:0]), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  // position and pixel history
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [7:0]    prev1_q, prev1_d, prev2_q, prev2_d;
  logic          pend_v_q, pend_v_d;
  hent_t         pend_q, pend_d;
  logic          s1_v_q;
  hent_t         s1_q;
  logic          fwd_v_q;
  logic [CW-1:0] fwd_x_q;
  logic [15:0]   fwd_data_q;

  logic [CNTW-1:0] fifo_cnt;
  logic [SUMW-1:0] used, need_pend;
  logic [1:0]      n_s1, n_pix, n_pend;

  logic          wrap_col, h1_v, h2_v, accept, pend_go, issue_v;
  logic [HW-1:0] row_a, row_b;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [WW-1:0] col_nx;
  logic [7:0]    pix, a2;
  logic          ge1, ge2, rlast;
  hent_t         e1, e2, issue_e;

  assign pix      = s_axis_tdata;
  assign n_s1     = s1_v_q ? (2'(s1_q.ge1) + 2'(s1_q.rlast)) : 2'd0;
  assign n_pend   = 2'(pend_q.ge1) + 2'(pend_q.rlast);
  assign used     = SUMW'(fifo_cnt) + SUMW'(n_s1);
  assign need_pend = used + SUMW'(n_pend);

  assign s_axis_tready = !pend_v_q && (used + SUMW'(2) <= SUMW'(OUT_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pend_go       = pend_v_q && (need_pend <= SUMW'(OUT_DEPTH));

  always_comb begin
    wrap_col = {1'b0, col_q} >= w_q;
    row_a    = wrap_col ? ({1'b0, row_q} + HW'(1)) : {1'b0, row_q};
    c        = wrap_col ? '0 : col_q;
    r        = (row_a >= hh_q) ? '0 : row_a[RW-1:0];
    h1_v     = (c != '0);
    h2_v     = ({1'b0, c} == w_q - WW'(1));
    ge1      = (r != '0);
    ge2      = (r > RW'(1));
    rlast    = ({1'b0, r} == hh_q - HW'(1));
    n_pix    = 2'(ge1) + 2'(rlast);
    a2       = h1_v ? prev1_q : pix;

    e1.h     = tap121(prev2_q, prev1_q, pix);
    e1.x     = c - CW'(1);
    e1.r     = r;
    e1.ge1   = ge1;
    e1.ge2   = ge2;
    e1.rlast = rlast;
    e1.lasth = !h2_v;

    e2       = e1;
    e2.h     = tap121(a2, pix, pix);
    e2.x     = c;
    e2.lasth = 1'b1;

    col_nx  = {1'b0, c} + WW'(1);
    row_b   = {1'b0, r} + HW'(1);
    col_d   = col_q;
    row_d   = row_q;
    prev1_d = prev1_q;
    prev2_d = prev2_q;
    if (accept) begin
      prev2_d = a2;
      prev1_d = pix;
      if (col_nx >= w_q) begin
        col_d = '0;
        row_d = (row_b >= hh_q) ? '0 : row_b[RW-1:0];
      end else begin
        col_d = col_nx[CW-1:0];
        row_d = r;
      end
    end

    issue_v  = pend_go || (accept && (h1_v || h2_v));
    issue_e  = pend_go ? pend_q : (h1_v ? e1 : e2);
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    if (pend_go) begin
      pend_v_d = 1'b0;
    end else if (accept && h1_v && h2_v) begin
      pend_v_d = 1'b1;
      pend_d   = e2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      prev1_q  <= '0;
      prev2_q  <= '0;
      pend_v_q <= 1'b0;
      s1_v_q   <= 1'b0;
      fwd_v_q  <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      prev1_q  <= prev1_d;
      prev2_q  <= prev2_d;
      pend_v_q <= pend_v_d;
      s1_v_q   <= issue_v;
      fwd_v_q  <= s1_v_q;
    end
  end

  // line store word: older row in the upper byte, newer row in the lower byte
  logic [15:0] ram_rdata, rd_word, wr_word;

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    s1_q       <= issue_e;
    fwd_x_q    <= s1_q.x;
    fwd_data_q <= wr_word;
  end

  assign rd_word = (fwd_v_q && (fwd_x_q == s1_q.x)) ? fwd_data_q : ram_rdata;
  assign wr_word = {rd_word[7:0], s1_q.h};

  blur3_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_q.x),
    .wdata_i (wr_word),
    .re_i    (issue_v),
    .raddr_i (issue_e.x),
    .rdata_o (ram_rdata)
  );

  // vertical pass
  logic [7:0]       older, newer, above_a, above_b;
  logic [RW+COL_W-1:0] x_ext;
  logic [RW+ROW_W-1:0] r_ext, rm1_ext;
  res_t             res_a, res_b, push0;
  logic [1:0]       push_n;

  always_comb begin
    older   = rd_word[15:8];
    newer   = rd_word[7:0];
    above_a = s1_q.ge2 ? older : newer;
    above_b = s1_q.ge1 ? newer : s1_q.h;
    x_ext   = (RW+COL_W)'(s1_q.x);
    r_ext   = (RW+ROW_W)'(s1_q.r);
    rm1_ext = (RW+ROW_W)'(s1_q.r - RW'(1));

    res_a.value = tap121(above_a, newer, s1_q.h);
    res_a.col   = x_ext[COL_W-1:0];
    res_a.row   = rm1_ext[ROW_W-1:0];
    res_a.last  = s1_q.lasth && !s1_q.rlast;

    res_b.value = tap121(above_b, s1_q.h, s1_q.h);
    res_b.col   = x_ext[COL_W-1:0];
    res_b.row   = r_ext[ROW_W-1:0];
    res_b.last  = s1_q.lasth;

    push0  = s1_q.ge1 ? res_a : res_b;
    push_n = n_s1;
  end

  res_t head;

  blur3_ofifo #(
    .DEPTH (OUT_DEPTH)
  ) u_ofifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (push0),
    .push1_i  (res_b),
    .pop_i    (m_axis_tready),
    .head_o   (head),
    .valid_o  (m_axis_tvalid),
    .cnt_o    (fifo_cnt)
  );

  assign m_axis_tdata = {1'b0, head.row, head.col, head.value};
  assign m_axis_tlast = head.last;

endmodule

/* bench/blur_3x3_separable_121_tb.sv */
module blur_3x3_separable_121_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blur3_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 80;

  typedef enum int unsigned {PIX_ANY, PIX_RAIL, PIX_NEAR} pix_mix_e;

  class blur_tracker;
    bit [7:0] hrow_older [DEF_MAX_WIDTH];
    bit [7:0] hrow_newer [DEF_MAX_WIDTH];
    bit [7:0] px_one;
    bit [7:0] px_two;
    int unsigned col_pos;
    int unsigned row_pos;
    bit [CFG_WIDTH_W-1:0] width_reg;
    bit [CFG_HEIGHT_W-1:0] height_reg;
    res_t blurred_due[$];
    int unsigned n_bad;

    function new();
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = val[CFG_WIDTH_W-1:0];
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = val[CFG_HEIGHT_W-1:0];
      end
    endfunction

    function bit [7:0] tap121(bit [7:0] a, bit [7:0] b, bit [7:0] c);
      bit [9:0] sum;
      sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
      return sum[9:2];
    endfunction

    function void push(bit [7:0] v, int unsigned x, int unsigned y);
      res_t r;
      r.value = v;
      r.col = x[COL_W-1:0];
      r.row = y[ROW_W-1:0];
      r.last = 1'b0;
      blurred_due.push_back(r);
    endfunction

    function int unsigned vpass(bit [7:0] h, int unsigned x, int unsigned r,
                                int unsigned rows);
      bit [7:0] nw;
      bit [7:0] od;
      int unsigned n;
      nw = hrow_newer[x];
      od = hrow_older[x];
      n = 0;
      if (r >= 1) begin
        push(tap121((r >= 2) ? od : nw, nw, h), x, r - 1);
        n++;
      end
      if (r == rows - 1) begin
        push(tap121((r >= 1) ? nw : h, h, h), x, r);
        n++;
      end
      hrow_older[x] = nw;
      hrow_newer[x] = h;
      return n;
    endfunction

    function void note_pixel(bit [7:0] p);
      int unsigned w;
      int unsigned hh;
      int unsigned n;
      w = width_reg;
      hh = height_reg;
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      if (hh < 1) hh = 1;
      if (hh > DEF_MAX_HEIGHT) hh = DEF_MAX_HEIGHT;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= hh) row_pos = 0;
      n = 0;
      if (col_pos == 0) begin
        px_two = p;
        px_one = p;
      end
      if (col_pos >= 1) n += vpass(tap121(px_two, px_one, p), col_pos - 1, row_pos, hh);
      px_two = px_one;
      px_one = p;
      if (col_pos == w - 1) begin
        n += vpass(tap121(px_two, px_one, px_one), col_pos, row_pos, hh);
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= hh) row_pos = 0;
      end
      if (n > 0) blurred_due[blurred_due.size() - 1].last = 1'b1;
    endfunction

    function void field_ok(string name, res_t want, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch at col %0d row %0d: expected %0d, actual %0d",
                 $time, name, want.col, want.row, exp_v, act_v);
        n_bad++;
      end
    endfunction

    function void check_blurred(res_t got);
      res_t want;
      if (blurred_due.size() == 0) begin
        $display({"%0t: unexpected result: expected none, ",
                  "actual value %0d col %0d row %0d last %0b"},
                 $time, got.value, got.col, got.row, got.last);
        n_bad++;
        return;
      end
      want = blurred_due.pop_front();
      field_ok("value", want, want.value, got.value);
      field_ok("col", want, want.col, got.col);
      field_ok("row", want, want.row, got.row);
      field_ok("last", want, want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [7:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [31:0] m_data;
  logic m_last;

  blur_tracker sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int unsigned sent = 0;
  int unsigned cycles = 0;

  blur_3x3_separable_121 uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned hold_cnt;
    res_t got;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (m_valid && m_ready) begin
        got.value = m_data[7:0];
        got.col = m_data[18:8];
        got.row = m_data[30:19];
        got.last = m_last;
        sb.check_blurred(got);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD - 1;
        m_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        hold_cnt = $urandom_range(0, 9);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick(pix_mix_e mix);
    case (mix)
      PIX_RAIL: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_NEAR: return 8'(120 + $urandom_range(0, 15));
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(logic [7:0] p);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= p;
    do @(posedge clk); while (!s_ready);
    sb.note_pixel(p);
    sent++;
  endtask

  task automatic feed(int unsigned count, pix_mix_e mix);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick(mix));
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (sb.blurred_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= REG_IMAGE_WIDTH;
    cfg_data <= w[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_reg(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
    cfg_idx <= REG_IMAGE_HEIGHT;
    cfg_data <= h[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_reg(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned planes;
    int unsigned phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single column, tallest plane; stop at a row boundary
    set_size(0, 8191);
    feed(4, PIX_RAIL);
    // row count past the new height starts a new plane
    set_size(5, 3);
    feed(7, PIX_ANY);
    // column count past the new width forces a new row, then a new plane
    set_size(2, 2);
    feed(4, PIX_ANY);
    // widest row, single row plane
    set_size(4095, 0);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    set_size(3, 1);
    feed(3, PIX_ANY);

    phase = 0;
    while (sent < 165) begin
      if (phase == 1) begin
        w = 9;
        h = 6;
        planes = 1;
      end else begin
        w = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 9);
        h = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
        planes = $urandom_range(1, 2);
        if ($urandom_range(0, 7) == 0) begin
          w = $urandom_range(10, 48);
          h = 2;
          planes = 1;
        end
      end
      quiet = (sent >= 130) ? 1'b1 : ($urandom_range(0, 3) == 0);
      set_size(w, h);
      if (phase == 1) begin
        quiet = 1'b0;
        hold_req = 1'b1;
      end
      feed(planes * w * h, pix_mix_e'($urandom_range(0, 2)));
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.n_bad == 0 && sb.blurred_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/blur3_pkg.sv
rtl/core/blur3_ram.sv
rtl/core/blur3_ofifo.sv
rtl/core/blur_3x3_separable_121.sv
bench/blur_3x3_separable_121_tb.sv
